>>> sv/lcfd_pkg.sv
// lcfd_pkg: shared types and constants of the LED cube frame driver.
// Holds opcodes, the command record passed front to back, and sizes.
// No dependencies.
`default_nettype none
package lcfd_pkg;

  localparam int unsigned CUBE_EDGE_DEF = 8;
  localparam int unsigned STORE_DEPTH   = 64;
  localparam int unsigned STORE_AW      = $clog2(STORE_DEPTH);
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_VOX_ON  = 4'd1;
  localparam logic [3:0] OP_VOX_OFF = 4'd2;
  localparam logic [3:0] OP_ROW     = 4'd3;
  localparam logic [3:0] OP_COL_OFF = 4'd4;
  localparam logic [3:0] OP_CLEAR   = 4'd5;
  localparam logic [3:0] OP_XY_ON   = 4'd6;
  localparam logic [3:0] OP_XY_OFF  = 4'd7;
  localparam logic [3:0] OP_YZ_ON   = 4'd8;
  localparam logic [3:0] OP_YZ_OFF  = 4'd9;
  localparam logic [3:0] OP_XZ_ON   = 4'd10;
  localparam logic [3:0] OP_XZ_OFF  = 4'd11;

  typedef enum logic [2:0] {
    K_TICK,
    K_SET_BIT,
    K_CLR_BIT,
    K_WRITE,
    K_CLEAR_ALL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] z;
    logic [2:0] y;
    logic [7:0] bit_mask;
    logic [7:0] value;
    logic       sweep_z;
    logic       sweep_y;
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/lcfd_front.sv
// lcfd_front: accepts draw and tick items, range-checks them and turns
// them into command records for the queue. Uses lcfd_pkg.
`default_nettype none
module lcfd_front #(
  parameter int unsigned CubeEdge = lcfd_pkg::CUBE_EDGE_DEF
) (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [3:0]    opcode_i,
  input  wire logic [7:0]    x_coord_i,
  input  wire logic [7:0]    y_coord_i,
  input  wire logic [7:0]    z_coord_i,
  input  wire logic [7:0]    row_bits_i,
  input  wire logic          full_i,
  output logic               push_o,
  output lcfd_pkg::cmd_t     cmd_o
);
  import lcfd_pkg::*;

  localparam logic [7:0] RowMask = 8'((1 << CubeEdge) - 1);
  localparam logic [7:0] Edge8   = 8'(CubeEdge);

  logic x_ok, y_ok, z_ok, keep;

  assign x_ok = x_coord_i < Edge8;
  assign y_ok = y_coord_i < Edge8;
  assign z_ok = z_coord_i < Edge8;

  always_comb begin
    keep           = 1'b0;
    cmd_o.kind     = K_TICK;
    cmd_o.z        = z_coord_i[2:0];
    cmd_o.y        = y_coord_i[2:0];
    cmd_o.bit_mask = 8'd1 << x_coord_i[2:0];
    cmd_o.value    = 8'd0;
    cmd_o.sweep_z  = 1'b0;
    cmd_o.sweep_y  = 1'b0;
    case (opcode_i)
      OP_TICK: begin
        keep          = 1'b1;
        cmd_o.kind    = K_TICK;
        cmd_o.sweep_y = 1'b1;
      end
      OP_VOX_ON, OP_VOX_OFF: begin
        keep       = x_ok && y_ok && z_ok;
        cmd_o.kind = (opcode_i == OP_VOX_ON) ? K_SET_BIT : K_CLR_BIT;
      end
      OP_ROW: begin
        keep        = y_ok && z_ok;
        cmd_o.kind  = K_WRITE;
        cmd_o.value = row_bits_i & RowMask;
      end
      OP_COL_OFF: begin
        keep          = x_ok && y_ok;
        cmd_o.kind    = K_CLR_BIT;
        cmd_o.sweep_z = 1'b1;
      end
      OP_CLEAR: begin
        keep       = 1'b1;
        cmd_o.kind = K_CLEAR_ALL;
      end
      OP_XY_ON, OP_XY_OFF: begin
        keep          = z_ok;
        cmd_o.kind    = K_WRITE;
        cmd_o.value   = (opcode_i == OP_XY_ON) ? RowMask : 8'd0;
        cmd_o.sweep_y = 1'b1;
      end
      OP_YZ_ON, OP_YZ_OFF: begin
        keep          = x_ok;
        cmd_o.kind    = (opcode_i == OP_YZ_ON) ? K_SET_BIT : K_CLR_BIT;
        cmd_o.sweep_y = 1'b1;
        cmd_o.sweep_z = 1'b1;
      end
      OP_XZ_ON, OP_XZ_OFF: begin
        keep          = y_ok;
        cmd_o.kind    = K_WRITE;
        cmd_o.value   = (opcode_i == OP_XZ_ON) ? RowMask : 8'd0;
        cmd_o.sweep_z = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule
`default_nettype wire

>>> sv/lcfd_cmd_fifo.sv
// lcfd_cmd_fifo: short command queue between front and back.
// Uses lcfd_pkg for the command record and queue depth.
`default_nettype none
module lcfd_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lcfd_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output lcfd_pkg::cmd_t       cmd_o
);
  import lcfd_pkg::*;

  localparam logic [QPTR_W-1:0] PtrMax = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CntMax = QCNT_W'(QDEPTH);

  cmd_t                entries_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == CntMax;
  assign empty_o = cnt_q == '0;
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/lcfd_back.sv
// lcfd_back: executes queued commands on the frame store and streams
// refresh rows out. Holds the 64x8 store, its valid bits and the layer.
// Uses lcfd_pkg.
`default_nettype none
module lcfd_back #(
  parameter int unsigned CubeEdge = lcfd_pkg::CUBE_EDGE_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire lcfd_pkg::cmd_t  cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [2:0]           latch_addr_o,
  output logic [7:0]           row_data_o,
  output logic [7:0]           layer_enable_o,
  output logic                 last_o
);
  import lcfd_pkg::*;

  localparam logic [2:0] EdgeMax = 3'(CubeEdge - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_EMIT
  } state_e;

  state_e               state_q;
  cmd_t                 cmd_q;
  logic [2:0]           cy_q, cz_q, layer_q;
  logic [STORE_DEPTH-1:0] vld_q;
  logic [7:0]           mem_q [STORE_DEPTH];
  logic [7:0]           rdata_q;
  logic                 out_v_q, last_q;
  logic [2:0]           latch_q;
  logic [7:0]           row_q, en_q;

  logic [2:0]           zsel, ysel;
  logic [STORE_AW-1:0]  cur_addr, rd_addr;
  logic                 rd_en, wr_en, out_free, last_row, done;
  logic [7:0]           wr_data;

  assign zsel     = (cmd_q.kind == K_TICK) ? layer_q : (cmd_q.sweep_z ? cz_q : cmd_q.z);
  assign ysel     = cmd_q.sweep_y ? cy_q : cmd_q.y;
  assign cur_addr = {zsel, ysel};
  assign out_free = !out_v_q || !out_stall_i;
  assign last_row = cy_q == EdgeMax;
  assign done     = (!cmd_q.sweep_y || cy_q == EdgeMax) && (!cmd_q.sweep_z || cz_q == EdgeMax);
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_addr;
    wr_en   = 1'b0;
    case (cmd_q.kind)
      K_WRITE:   wr_data = cmd_q.value;
      K_SET_BIT: wr_data = rdata_q | cmd_q.bit_mask;
      default:   wr_data = rdata_q & ~cmd_q.bit_mask;
    endcase
    case (state_q)
      S_RD: begin
        rd_en = 1'b1;
      end
      S_WR: begin
        wr_en = 1'b1;
      end
      S_EMIT: begin
        rd_en   = out_free && !last_row;
        rd_addr = {layer_q, cy_q + 3'd1};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= vld_q[rd_addr] ? mem_q[rd_addr] : 8'd0;
    end
    if (wr_en) begin
      mem_q[cur_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      layer_q <= '0;
      vld_q   <= '0;
      out_v_q <= 1'b0;
      last_q  <= 1'b0;
      latch_q <= '0;
      row_q   <= '0;
      en_q    <= '0;
    end else begin
      if (out_v_q && !out_stall_i && state_q != S_EMIT) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cmd_q <= cmd_i;
            cy_q  <= '0;
            cz_q  <= '0;
            case (cmd_i.kind)
              K_CLEAR_ALL: vld_q   <= '0;
              K_WRITE:     state_q <= S_WR;
              default:     state_q <= S_RD;
            endcase
          end
        end
        S_RD: begin
          state_q <= (cmd_q.kind == K_TICK) ? S_EMIT : S_WR;
        end
        S_WR: begin
          vld_q[cur_addr] <= 1'b1;
          if (done) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= (cmd_q.kind == K_WRITE) ? S_WR : S_RD;
            if (cmd_q.sweep_y && cy_q != EdgeMax) begin
              cy_q <= cy_q + 3'd1;
            end else begin
              cy_q <= '0;
              cz_q <= cz_q + 3'd1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_v_q <= 1'b1;
            latch_q <= cy_q + 3'd1;
            row_q   <= rdata_q;
            last_q  <= last_row;
            en_q    <= last_row ? (8'd1 << layer_q) : 8'd0;
            if (last_row) begin
              layer_q <= (layer_q == EdgeMax) ? 3'd0 : layer_q + 3'd1;
              state_q <= S_IDLE;
            end else begin
              cy_q <= cy_q + 3'd1;
            end
          end else begin
            out_v_q <= out_v_q;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_v_q;
  assign latch_addr_o   = latch_q;
  assign row_data_o     = row_q;
  assign layer_enable_o = en_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

>>> sv/led_cube_frame_driver_unit.sv
// led_cube_frame_driver_unit: frame store and layer multiplexer of an LED cube.
// Ticks: a tick is popped in S_IDLE, its first row read in S_RD and shown
// from S_EMIT, then one row per cycle while the output is not stalled
// (CubeEdge rows per tick). Draw commands: S_WR per touched row for writes,
// S_RD then S_WR for set/clear (yz: CubeEdge^2 rows); clear all in S_IDLE.
// Reset clears the store (valid bits), the layer counter and the command queue.
`default_nettype none
module led_cube_frame_driver_unit #(
  parameter int unsigned CubeEdge = lcfd_pkg::CUBE_EDGE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [7:0]  x_coord_i,
  input  wire logic [7:0]  y_coord_i,
  input  wire logic [7:0]  z_coord_i,
  input  wire logic [7:0]  row_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       latch_addr_o,
  output logic [7:0]       row_data_o,
  output logic [7:0]       layer_enable_o,
  output logic             last_o
);
  import lcfd_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, empty;

  lcfd_front #(
    .CubeEdge(CubeEdge)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .z_coord_i  (z_coord_i),
    .row_bits_i (row_bits_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  lcfd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (queue_cmd)
  );

  lcfd_back #(
    .CubeEdge(CubeEdge)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .cmd_i          (queue_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .latch_addr_o   (latch_addr_o),
    .row_data_o     (row_data_o),
    .layer_enable_o (layer_enable_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
